// File: sv/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, constants and codes for the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int FPOS_W  = 4;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_FIND   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } ale_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [FPOS_W-1:0]        found_position;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     list_empty;
    } ale_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INSERT,
        S_DELETE,
        S_READ,
        S_READ_WAIT,
        S_FIND,
        S_RESULT
    } ale_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       mem_rd;
        logic       clr_pend;
        logic       wr_pend;
        logic       wr_val;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cap_rval;
        logic       cap_found;
        logic       set_stat;
        logic [1:0] stat_code;
        logic       emit;
    } ale_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       range_bad;
        logic       full;
        logic       idx_gt_pos;
        logic       more_del;
        logic       idx_lt_count;
        logic       pend;
        logic       match;
        logic       out_free;
    } ale_stat_t;

endpackage

`default_nettype wire

// File: sv/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of up to 16 signed 32-bit entries with insert, delete, read
// and find commands, one result item per command item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one command item:
//   command, position and value. Output channel (out_valid / out_ready /
//   out_data) returns one result item per command: result_value,
//   found_position, status, entry_count and list_empty.
//   Work per item:
//     insert  : moves entries position..count-1 up one, writes the value
//     delete  : moves entries after position down one
//     read    : reads the entry at position
//     find    : scans up from entry 0 to the first match or to count
//     a command out of range, or an insert into a full list, is rejected
//   Items are handled one at a time; the walk over the store moves one entry
//   a cycle through a single write port and a registered read port.
//   The next item is taken as soon as the result sits in the output register,
//   even when the receiver has not taken it yet. A stalled receiver holds the
//   result; a following result waits in the controller until the register
//   frees up.
//   Reset empties the list (count zero); store contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ale_pkg::ale_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ale_pkg::ale_out_t      out_data
);

    ale_pkg::ale_cmd_t  cmd;   // controller commands
    ale_pkg::ale_stat_t stat;  // datapath status

    // sequence each item: check, walk the store, post the result
    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the list, count, walk index and output register
    ale_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // never drive both store writes at once
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_pend && cmd.wr_val))
        else $error("store write conflict");

    // post a result only when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result overwrote a pending item");

    // reported count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.entry_count <= ale_pkg::COUNT_W'(ale_pkg::DEPTH)))
        else $error("entry count beyond depth");

    // empty flag tracks the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.list_empty == (out_data.entry_count == '0)))
        else $error("empty flag mismatch");

endmodule

`default_nettype wire

// File: sv/ale_ram.sv
// ----------------------------------------------------------------------------
// ale_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/ale_dp.sv
// ----------------------------------------------------------------------------
// ale_dp
// Datapath: list store, entry count, walk index, result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ale_pkg::ale_in_t in_data,
    input  wire ale_pkg::ale_cmd_t cmd,
    output ale_pkg::ale_stat_t    stat,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ale_pkg::ale_out_t     out_data
);

    logic [1:0]                    cmd_reg;
    logic [ale_pkg::POS_W-1:0]     pos_reg;
    logic [ale_pkg::DATA_W-1:0]    val_reg;
    logic [ale_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [ale_pkg::COUNT_W-1:0]   idx_reg;
    logic                          pend_reg, pend_next;
    logic [ale_pkg::ADDR_W-1:0]    pend_addr_reg;
    logic [ale_pkg::DATA_W-1:0]    rval_reg;
    logic [ale_pkg::FPOS_W-1:0]    fpos_reg;
    logic [1:0]                    stat_reg;
    logic                          out_valid_reg;
    ale_pkg::ale_out_t             out_reg;

    logic [ale_pkg::COUNT_W-1:0]   idx_dn;
    logic [ale_pkg::COUNT_W:0]     idx_up;
    logic [ale_pkg::COUNT_W-1:0]   rd_idx;
    logic [ale_pkg::COUNT_W-1:0]   idx_step;
    logic [ale_pkg::DATA_W-1:0]    rd_data;
    logic                          ram_we;
    logic [ale_pkg::ADDR_W-1:0]    ram_waddr;
    logic [ale_pkg::DATA_W-1:0]    ram_wdata;

    assign idx_dn = idx_reg - ale_pkg::COUNT_W'(1);
    assign idx_up = {1'b0, idx_reg} + (ale_pkg::COUNT_W + 1)'(1);

    // read address and index step by walk direction
    always_comb
    begin
        case (cmd_reg)
            ale_pkg::CMD_INSERT:
            begin
                rd_idx   = idx_dn;
                idx_step = idx_dn;
            end
            ale_pkg::CMD_DELETE:
            begin
                rd_idx   = idx_up[ale_pkg::COUNT_W-1:0];
                idx_step = idx_up[ale_pkg::COUNT_W-1:0];
            end
            ale_pkg::CMD_READ:
            begin
                rd_idx   = idx_reg;
                idx_step = idx_reg;
            end
            default:
            begin
                rd_idx   = idx_reg;
                idx_step = idx_up[ale_pkg::COUNT_W-1:0];
            end
        endcase
    end

    assign ram_we    = cmd.wr_pend || cmd.wr_val;
    assign ram_waddr = cmd.wr_val ? pos_reg[ale_pkg::ADDR_W-1:0] : pend_addr_reg;
    assign ram_wdata = cmd.wr_val ? val_reg : rd_data;

    ale_ram #(
        .WIDTH (ale_pkg::DATA_W),
        .DEPTH (ale_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.mem_rd),
        .raddr (rd_idx[ale_pkg::ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + ale_pkg::COUNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - ale_pkg::COUNT_W'(1);
        end

        pend_next = pend_reg;
        if (cmd.load || cmd.clr_pend)
        begin
            pend_next = 1'b0;
        end
        if (cmd.mem_rd)
        begin
            pend_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= in_data.command;
            pos_reg  <= in_data.position;
            val_reg  <= in_data.value;
            rval_reg <= '0;
            fpos_reg <= '0;
            stat_reg <= ale_pkg::ST_OK;
            case (in_data.command)
                ale_pkg::CMD_INSERT: idx_reg <= count_reg;
                ale_pkg::CMD_FIND:   idx_reg <= '0;
                default:             idx_reg <= ale_pkg::COUNT_W'(in_data.position);
            endcase
        end
        if (cmd.mem_rd)
        begin
            // the walk writes back to, or reports, the entry the index points at
            pend_addr_reg <= idx_reg[ale_pkg::ADDR_W-1:0];
            idx_reg       <= idx_step;
        end
        if (cmd.cap_rval)
        begin
            rval_reg <= rd_data;
        end
        if (cmd.cap_found)
        begin
            fpos_reg <= ale_pkg::FPOS_W'(pend_addr_reg);
        end
        if (cmd.set_stat)
        begin
            stat_reg <= cmd.stat_code;
        end
        if (cmd.emit)
        begin
            out_reg.result_value   <= rval_reg;
            out_reg.found_position <= fpos_reg;
            out_reg.status         <= stat_reg;
            out_reg.entry_count    <= count_reg;
            out_reg.list_empty     <= (count_reg == '0);
        end
    end

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.range_bad    = (cmd_reg == ale_pkg::CMD_INSERT)
                            ? (ale_pkg::COUNT_W'(pos_reg) > count_reg) || pos_reg[ale_pkg::POS_W-1]
                                && (count_reg < ale_pkg::COUNT_W'(ale_pkg::DEPTH))
                            : (ale_pkg::COUNT_W'(pos_reg) >= count_reg);
        stat.full         = (count_reg >= ale_pkg::COUNT_W'(ale_pkg::DEPTH));
        stat.idx_gt_pos   = (idx_reg > ale_pkg::COUNT_W'(pos_reg));
        stat.more_del     = (idx_up < {1'b0, count_reg});
        stat.idx_lt_count = (idx_reg < count_reg);
        stat.pend         = pend_reg;
        stat.match        = pend_reg && (rd_data == val_reg);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: sv/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Controller: sequences each command through check, walk and result states.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ale_pkg::ale_stat_t stat,
    output ale_pkg::ale_cmd_t      cmd
);

    ale_pkg::ale_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ale_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ale_pkg::S_CHECK;
                end
            end
            ale_pkg::S_CHECK:
            begin
                case (stat.cmd)
                    ale_pkg::CMD_INSERT:
                        state_next = (stat.range_bad || stat.full) ? ale_pkg::S_RESULT
                                                                   : ale_pkg::S_INSERT;
                    ale_pkg::CMD_DELETE:
                        state_next = stat.range_bad ? ale_pkg::S_RESULT : ale_pkg::S_DELETE;
                    ale_pkg::CMD_READ:
                        state_next = stat.range_bad ? ale_pkg::S_RESULT : ale_pkg::S_READ;
                    default:
                        state_next = ale_pkg::S_FIND;
                endcase
            end
            ale_pkg::S_INSERT:
            begin
                if (!stat.pend && !stat.idx_gt_pos)
                begin
                    state_next = ale_pkg::S_RESULT;
                end
            end
            ale_pkg::S_DELETE:
            begin
                if (!stat.pend && !stat.more_del)
                begin
                    state_next = ale_pkg::S_RESULT;
                end
            end
            ale_pkg::S_READ:
                state_next = ale_pkg::S_READ_WAIT;
            ale_pkg::S_READ_WAIT:
                state_next = ale_pkg::S_RESULT;
            ale_pkg::S_FIND:
            begin
                if (stat.match || (!stat.idx_lt_count && !stat.pend))
                begin
                    state_next = ale_pkg::S_RESULT;
                end
            end
            ale_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ale_pkg::S_IDLE;
                end
            end
            default:
                state_next = ale_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ale_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ale_pkg::S_CHECK:
            begin
                case (stat.cmd)
                    ale_pkg::CMD_INSERT:
                    begin
                        cmd.set_stat  = stat.range_bad || stat.full;
                        cmd.stat_code = stat.range_bad ? ale_pkg::ST_RANGE : ale_pkg::ST_FULL;
                    end
                    ale_pkg::CMD_DELETE, ale_pkg::CMD_READ:
                    begin
                        cmd.set_stat  = stat.range_bad;
                        cmd.stat_code = ale_pkg::ST_RANGE;
                    end
                    default:
                    begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ale_pkg::ST_NOTFOUND;
                    end
                endcase
            end
            ale_pkg::S_INSERT:
            begin
                cmd.wr_pend  = stat.pend;
                cmd.mem_rd   = stat.idx_gt_pos;
                cmd.clr_pend = stat.pend && !stat.idx_gt_pos;
                cmd.wr_val   = !stat.pend && !stat.idx_gt_pos;
                cmd.cnt_inc  = !stat.pend && !stat.idx_gt_pos;
            end
            ale_pkg::S_DELETE:
            begin
                cmd.wr_pend  = stat.pend;
                cmd.mem_rd   = stat.more_del;
                cmd.clr_pend = stat.pend && !stat.more_del;
                cmd.cnt_dec  = !stat.pend && !stat.more_del;
            end
            ale_pkg::S_READ:
                cmd.mem_rd = 1'b1;
            ale_pkg::S_READ_WAIT:
            begin
                cmd.cap_rval = 1'b1;
                cmd.clr_pend = 1'b1;
            end
            ale_pkg::S_FIND:
            begin
                if (stat.match)
                begin
                    cmd.cap_found = 1'b1;
                    cmd.set_stat  = 1'b1;
                    cmd.stat_code = ale_pkg::ST_OK;
                    cmd.clr_pend  = 1'b1;
                end
                else if (stat.idx_lt_count)
                begin
                    cmd.mem_rd = 1'b1;
                end
                else
                begin
                    cmd.clr_pend = 1'b1;
                end
            end
            ale_pkg::S_RESULT:
                cmd.emit = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire
